>>> hw/rtl/tvnt_pkg.sv
// ============================================================================
// tvnt_pkg
// Shared widths, register indexes and small helpers of the triangle vertex
// and normal transform unit.
// ============================================================================
package tvnt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_W         = 32;
    localparam int ACC_W         = 104;  // holds a cofactor times a normal sum
    localparam int PROD_W        = 66;   // 33 x 33 signed product
    localparam int OPB_W         = 33;
    localparam int DATA_W        = 192;
    localparam int USER_W        = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_W         = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_M00_M01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_M02_M03 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_M10_M11 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_M12_M13 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_M20_M21 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_M22_M23 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_VN  = 3'd6;

    typedef logic [5:0][CFG_W-1:0] t_mat_regs;

    // next index modulo three
    function automatic logic [1:0] inc3(input logic [1:0] v);
        return (v == 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    // flat index of element c of group k in a 3x3 buffer
    function automatic logic [3:0] idx9(input logic [1:0] k, input logic [1:0] c);
        return {1'b0, k, 1'b0} + {2'b00, k} + {2'b00, c};
    endfunction

    // matrix entry (r, c); column 3 is the translation
    function automatic logic [VAL_W-1:0] mat_get(input t_mat_regs m,
                                                 input logic [1:0] r,
                                                 input logic [1:0] c);
        logic [2:0]       sel;
        logic [CFG_W-1:0] w;
        sel = {r, 1'b0} + {2'b00, c[1]};
        w   = m[sel];
        return c[0] ? w[63:32] : w[31:0];
    endfunction

    function automatic logic [ACC_W-1:0] sx_acc(input logic [VAL_W-1:0] v);
        return {{(ACC_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

    function automatic logic [OPB_W-1:0] sx_b(input logic [VAL_W-1:0] v);
        return {v[VAL_W-1], v};
    endfunction

endpackage

>>> hw/rtl/triangle_vertex_normal_transform_unit.sv
// ============================================================================
// triangle_vertex_normal_transform_unit
// Transforms the three corners of a triangle by a 3x4 affine matrix and
// produces a unit normal per corner; its products share one 33x33 multiplier.
// ============================================================================
// Usage:
//  - Slave stream takes one corner per transfer: tdata holds pos_x, pos_y,
//    pos_z, norm_x, norm_y, norm_z (32 bits each, from bit 0 up).
//  - Master stream gives three results after every third corner, in arrival
//    order; tlast marks the third. tuser carries bary_corner, approx_normal
//    and fault.
//  - Config channel writes one register per transfer (index 0..6); it is
//    always ready; the user must write it only while the unit is idle, and
//    the unit itself does not enforce this.
//  - The first two corners of a triangle are taken one per cycle and stored.
//    The third starts the sequencer: each multiply-accumulate term runs over
//    three 32-bit digits (product register then add); the shift stage drops
//    one bit per cycle, then come the square root and the quotients. Vertex
//    normals take longer than face normals; a zero vector skips the square
//    root and the quotients.
//  - The input is not ready while a triangle is in work or its results wait.
//    A stalled receiver holds the current result and the unit stays busy.
//  - Reset loads the identity matrix, selects face normals and empties the
//    corner buffer.
// ============================================================================
module triangle_vertex_normal_transform_unit #(
    parameter int FRAC_BITS = tvnt_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z from bit 0 up
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [tvnt_pkg::DATA_W-1:0]          i_s_tdata,
    // out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [tvnt_pkg::DATA_W-1:0]          o_m_tdata,
    // bary_corner [1:0], approx_normal [2], fault [3]
    output logic [tvnt_pkg::USER_W-1:0]          o_m_tuser,
    output logic                                 o_m_tlast,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tvnt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tvnt_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int AW = tvnt_pkg::ACC_W;
    localparam int DW = FRAC_BITS + 32;
    localparam int JW = $clog2(DW);
    localparam logic [AW-1:0] ROUND_HALF = AW'(1) << (FRAC_BITS - 1);
    localparam logic [31:0]   ONE_FX     = 32'(1) << FRAC_BITS;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_PINIT  = 5'd1;
    localparam logic [4:0] ST_PMAC   = 5'd2;
    localparam logic [4:0] ST_PSTO   = 5'd3;
    localparam logic [4:0] ST_CMAC   = 5'd4;
    localparam logic [4:0] ST_CSTO   = 5'd5;
    localparam logic [4:0] ST_DMAC   = 5'd6;
    localparam logic [4:0] ST_DSTO   = 5'd7;
    localparam logic [4:0] ST_NMAC   = 5'd8;
    localparam logic [4:0] ST_NSTO   = 5'd9;
    localparam logic [4:0] ST_FMAC   = 5'd10;
    localparam logic [4:0] ST_FSTO   = 5'd11;
    localparam logic [4:0] ST_UABS   = 5'd12;
    localparam logic [4:0] ST_USHF   = 5'd13;
    localparam logic [4:0] ST_USQ    = 5'd14;
    localparam logic [4:0] ST_USQRT  = 5'd15;
    localparam logic [4:0] ST_UDINIT = 5'd16;
    localparam logic [4:0] ST_UDIV   = 5'd17;
    localparam logic [4:0] ST_UDSTO  = 5'd18;
    localparam logic [4:0] ST_USTO   = 5'd19;
    localparam logic [4:0] ST_OUT    = 5'd20;

    // control
    logic [4:0]          r_st;
    logic [1:0]          r_cnt;
    tvnt_pkg::t_mat_regs r_cfg;
    logic                r_uvn;
    logic [1:0]          r_k, r_r, r_c, r_d;
    logic                r_ph, r_t;
    logic                r_sat, r_approx, r_dneg;

    // datapath
    logic [31:0]            r_pin [0:8];
    logic [31:0]            r_nin [0:8];
    logic [31:0]            r_op  [0:8];
    logic [31:0]            r_on  [0:8];
    logic [AW-1:0]          r_cf  [0:8];
    logic [AW-1:0]          r_v   [0:2];
    logic [31:0]            r_un  [0:2];
    logic [2:0]             r_neg;
    logic signed [AW-1:0]   r_acc;
    logic signed [65:0]     r_prod;
    logic [63:0]            r_sqv, r_sqr, r_sqb;
    logic [31:0]            r_len;
    logic [DW-1:0]          r_dn;
    logic [31:0]            r_rem;
    logic [JW-1:0]          r_j;

    logic                   w_in_xfer;
    logic                   w_is_mac, w_mac_done;
    logic [AW-1:0]          w_opa;
    logic signed [32:0]     w_opb, w_dig;
    logic                   w_sub;
    logic signed [65:0]     w_mul;
    logic signed [AW-1:0]   w_pe, w_pe_sh, w_acc_nxt, w_pshift;
    logic                   w_p_ovf;
    logic [31:0]            w_p_sat;
    logic [32:0]            w_e1 [0:2];
    logic [32:0]            w_e2 [0:2];
    logic [1:0]             w_a, w_b, w_x, w_y;
    logic                   w_big, w_zero;
    logic [63:0]            w_sq_try;
    logic [32:0]            w_rem_sh, w_d2, w_rem_nxt;
    logic                   w_div_ge;
    logic [3:0]             w_oi0, w_oi1, w_oi2;

    assign o_s_tready  = (r_st == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_s_tvalid & o_s_tready;

    // rotated row and column picks for cofactors and the cross product
    assign w_a = tvnt_pkg::inc3(r_r);
    assign w_b = tvnt_pkg::inc3(w_a);
    assign w_x = tvnt_pkg::inc3(r_c);
    assign w_y = tvnt_pkg::inc3(w_x);

    // triangle edges from the transformed positions
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_e1[i] = {r_op[3+i][31], r_op[3+i]} - {r_op[i][31], r_op[i]};
            w_e2[i] = {r_op[6+i][31], r_op[6+i]} - {r_op[i][31], r_op[i]};
        end
    end

    // operand select for the shared multiply-accumulate
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        w_sub = 1'b0;
        case (r_st)
            ST_PMAC: begin
                w_opa = tvnt_pkg::sx_acc(r_pin[tvnt_pkg::idx9(r_k, r_c)]);
                w_opb = tvnt_pkg::sx_b(tvnt_pkg::mat_get(r_cfg, r_r, r_c));
            end
            ST_CMAC: begin
                w_opa = tvnt_pkg::sx_acc(tvnt_pkg::mat_get(r_cfg, w_a, r_t ? w_y : w_x));
                w_opb = tvnt_pkg::sx_b(tvnt_pkg::mat_get(r_cfg, w_b, r_t ? w_x : w_y));
                w_sub = r_t;
            end
            ST_DMAC: begin
                w_opa = r_cf[tvnt_pkg::idx9(2'd0, r_c)];
                w_opb = tvnt_pkg::sx_b(tvnt_pkg::mat_get(r_cfg, 2'd0, r_c));
            end
            ST_NMAC: begin
                w_opa = r_approx ? tvnt_pkg::sx_acc(tvnt_pkg::mat_get(r_cfg, r_r, r_c))
                                 : r_cf[tvnt_pkg::idx9(r_r, r_c)];
                w_opb = tvnt_pkg::sx_b(r_nin[tvnt_pkg::idx9(r_k, r_c)]);
                w_sub = !r_approx && r_dneg;
            end
            ST_FMAC: begin
                w_opa = {{(AW-33){w_e1[r_t ? w_b : w_a][32]}}, w_e1[r_t ? w_b : w_a]};
                w_opb = w_e2[r_t ? w_a : w_b];
                w_sub = r_t;
            end
            ST_USQ: begin
                w_opa = r_v[r_c];
                w_opb = r_v[r_c][32:0];
            end
            default: begin
                w_opa = '0;
            end
        endcase
    end

    // one 32-bit digit of operand A per product
    always_comb begin
        case (r_d)
            2'd0:    w_dig = {1'b0, w_opa[31:0]};
            2'd1:    w_dig = {1'b0, w_opa[63:32]};
            default: w_dig = {w_opa[95], w_opa[95:64]};
        endcase
    end

    assign w_mul = w_dig * w_opb;

    // align registered product to its digit and accumulate
    always_comb begin
        w_pe = {{(AW-66){r_prod[65]}}, r_prod};
        case (r_d)
            2'd0:    w_pe_sh = w_pe;
            2'd1:    w_pe_sh = w_pe <<< 32;
            default: w_pe_sh = w_pe <<< 64;
        endcase
        w_acc_nxt = w_sub ? r_acc - w_pe_sh : r_acc + w_pe_sh;
    end

    assign w_is_mac   = (r_st inside {ST_PMAC, ST_CMAC, ST_DMAC, ST_NMAC, ST_FMAC, ST_USQ});
    assign w_mac_done = w_is_mac && r_ph && (r_d == 2'd2);

    // position scale back and saturation
    assign w_pshift = r_acc >>> FRAC_BITS;
    assign w_p_ovf  = ~(&w_pshift[AW-1:31]) & (|w_pshift[AW-1:31]);
    assign w_p_sat  = w_p_ovf ? (w_pshift[AW-1] ? 32'h8000_0000 : 32'h7fff_ffff)
                              : w_pshift[31:0];

    // normalize helpers
    assign w_big  = |(r_v[0][AW-1:30] | r_v[1][AW-1:30] | r_v[2][AW-1:30]);
    assign w_zero = ~|(r_v[0] | r_v[1] | r_v[2]);

    // square root and divide steps
    assign w_sq_try  = r_sqr + r_sqb;
    assign w_rem_sh  = {r_rem, r_dn[DW-1]};
    assign w_d2      = {r_len, 1'b0};
    assign w_div_ge  = (w_rem_sh >= w_d2);
    assign w_rem_nxt = w_div_ge ? w_rem_sh - w_d2 : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_cnt    <= 2'd0;
            r_cfg[0] <= 64'(ONE_FX);
            r_cfg[1] <= '0;
            r_cfg[2] <= {ONE_FX, 32'd0};
            r_cfg[3] <= '0;
            r_cfg[4] <= '0;
            r_cfg[5] <= 64'(ONE_FX);
            r_uvn    <= 1'b0;
            r_k      <= 2'd0;
            r_r      <= 2'd0;
            r_c      <= 2'd0;
            r_d      <= 2'd0;
            r_ph     <= 1'b0;
            r_t      <= 1'b0;
            r_sat    <= 1'b0;
            r_approx <= 1'b0;
            r_dneg   <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_valid) begin
                if (i_cfg_index == tvnt_pkg::CFG_USE_VN) begin
                    r_uvn <= i_cfg_data[0];
                end else if (i_cfg_index < tvnt_pkg::CFG_USE_VN) begin
                    r_cfg[i_cfg_index] <= i_cfg_data;
                end
            end

            // shared multiply-accumulate: product, then add
            if (w_is_mac) begin
                if (!r_ph) begin
                    r_prod <= w_mul;
                    r_ph   <= 1'b1;
                end else begin
                    r_acc <= w_acc_nxt;
                    r_ph  <= 1'b0;
                    r_d   <= (r_d == 2'd2) ? 2'd0 : r_d + 2'd1;
                end
            end

            // sequencer
            case (r_st)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        for (int i = 0; i < 3; i++) begin
                            r_pin[tvnt_pkg::idx9(r_cnt, 2'(i))] <= i_s_tdata[32*i +: 32];
                            r_nin[tvnt_pkg::idx9(r_cnt, 2'(i))] <= i_s_tdata[96+32*i +: 32];
                        end
                        if (r_cnt == 2'd2) begin
                            r_cnt    <= 2'd0;
                            r_k      <= 2'd0;
                            r_r      <= 2'd0;
                            r_sat    <= 1'b0;
                            r_approx <= 1'b0;
                            r_st     <= ST_PINIT;
                        end else begin
                            r_cnt <= r_cnt + 2'd1;
                        end
                    end
                end
                ST_PINIT: begin
                    r_acc <= (tvnt_pkg::sx_acc(tvnt_pkg::mat_get(r_cfg, r_r, 2'd3))
                              << FRAC_BITS) + ROUND_HALF;
                    r_c   <= 2'd0;
                    r_d   <= 2'd0;
                    r_ph  <= 1'b0;
                    r_st  <= ST_PMAC;
                end
                ST_PMAC: begin
                    if (w_mac_done) begin
                        if (r_c == 2'd2) r_st <= ST_PSTO;
                        else r_c <= r_c + 2'd1;
                    end
                end
                ST_PSTO: begin
                    r_op[tvnt_pkg::idx9(r_k, r_r)] <= w_p_sat;
                    if (w_p_ovf) r_sat <= 1'b1;
                    r_acc <= '0;
                    if (r_r != 2'd2) begin
                        r_r  <= r_r + 2'd1;
                        r_st <= ST_PINIT;
                    end else begin
                        r_r <= 2'd0;
                        if (r_k != 2'd2) begin
                            r_k  <= r_k + 2'd1;
                            r_st <= ST_PINIT;
                        end else begin
                            r_k  <= 2'd0;
                            r_c  <= 2'd0;
                            r_t  <= 1'b0;
                            r_st <= r_uvn ? ST_CMAC : ST_FMAC;
                        end
                    end
                end
                // cofactor (r, c): two products, second subtracted
                ST_CMAC: begin
                    if (w_mac_done) begin
                        if (!r_t) begin
                            r_t <= 1'b1;
                        end else begin
                            r_t  <= 1'b0;
                            r_st <= ST_CSTO;
                        end
                    end
                end
                ST_CSTO: begin
                    r_cf[tvnt_pkg::idx9(r_r, r_c)] <= r_acc;
                    r_acc <= '0;
                    if (r_c != 2'd2) begin
                        r_c  <= r_c + 2'd1;
                        r_st <= ST_CMAC;
                    end else begin
                        r_c <= 2'd0;
                        if (r_r != 2'd2) begin
                            r_r  <= r_r + 2'd1;
                            r_st <= ST_CMAC;
                        end else begin
                            r_r  <= 2'd0;
                            r_st <= ST_DMAC;
                        end
                    end
                end
                ST_DMAC: begin
                    if (w_mac_done) begin
                        if (r_c == 2'd2) r_st <= ST_DSTO;
                        else r_c <= r_c + 2'd1;
                    end
                end
                // determinant: only zero and sign are kept
                ST_DSTO: begin
                    r_approx <= (r_acc == '0);
                    r_dneg   <= r_acc[AW-1];
                    r_acc    <= '0;
                    r_c      <= 2'd0;
                    r_r      <= 2'd0;
                    r_k      <= 2'd0;
                    r_st     <= ST_NMAC;
                end
                ST_NMAC: begin
                    if (w_mac_done) begin
                        if (r_c == 2'd2) r_st <= ST_NSTO;
                        else r_c <= r_c + 2'd1;
                    end
                end
                ST_NSTO: begin
                    r_v[r_r] <= r_acc;
                    r_acc    <= '0;
                    r_c      <= 2'd0;
                    if (r_r != 2'd2) begin
                        r_r  <= r_r + 2'd1;
                        r_st <= ST_NMAC;
                    end else begin
                        r_r  <= 2'd0;
                        r_st <= ST_UABS;
                    end
                end
                // face normal component: e1[a]*e2[b] - e1[b]*e2[a]
                ST_FMAC: begin
                    if (w_mac_done) begin
                        if (!r_t) begin
                            r_t <= 1'b1;
                        end else begin
                            r_t  <= 1'b0;
                            r_st <= ST_FSTO;
                        end
                    end
                end
                ST_FSTO: begin
                    r_v[r_r] <= r_acc;
                    r_acc    <= '0;
                    if (r_r != 2'd2) begin
                        r_r  <= r_r + 2'd1;
                        r_st <= ST_FMAC;
                    end else begin
                        r_r  <= 2'd0;
                        r_st <= ST_UABS;
                    end
                end
                ST_UABS: begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= r_v[i][AW-1];
                        r_v[i]   <= r_v[i][AW-1] ? -r_v[i] : r_v[i];
                    end
                    r_st <= ST_USHF;
                end
                // shift magnitudes down one bit a cycle until all fit 30 bits
                ST_USHF: begin
                    if (w_zero) begin
                        r_un[0] <= '0;
                        r_un[1] <= '0;
                        r_un[2] <= ONE_FX;
                        r_st    <= ST_USTO;
                    end else if (w_big) begin
                        for (int i = 0; i < 3; i++) r_v[i] <= r_v[i] >> 1;
                    end else begin
                        r_acc <= '0;
                        r_c   <= 2'd0;
                        r_st  <= ST_USQ;
                    end
                end
                ST_USQ: begin
                    if (w_mac_done) begin
                        if (r_c == 2'd2) begin
                            r_sqv <= w_acc_nxt[63:0];
                            r_sqr <= '0;
                            r_sqb <= 64'h4000_0000_0000_0000;
                            r_st  <= ST_USQRT;
                        end else begin
                            r_c <= r_c + 2'd1;
                        end
                    end
                end
                // bitwise integer square root
                ST_USQRT: begin
                    if (r_sqb == '0) begin
                        r_len <= r_sqr[31:0];
                        r_c   <= 2'd0;
                        r_st  <= ST_UDINIT;
                    end else begin
                        if (r_sqv >= w_sq_try) begin
                            r_sqv <= r_sqv - w_sq_try;
                            r_sqr <= (r_sqr >> 1) + r_sqb;
                        end else begin
                            r_sqr <= r_sqr >> 1;
                        end
                        r_sqb <= r_sqb >> 2;
                    end
                end
                // rounded quotient (2t * one + len) / (2 len)
                ST_UDINIT: begin
                    r_dn  <= (DW'(r_v[r_c][29:0]) << (FRAC_BITS + 1)) + DW'(r_len);
                    r_rem <= '0;
                    r_j   <= '0;
                    r_st  <= ST_UDIV;
                end
                ST_UDIV: begin
                    r_rem <= w_rem_nxt[31:0];
                    r_dn  <= {r_dn[DW-2:0], w_div_ge};
                    r_j   <= r_j + JW'(1);
                    if (r_j == JW'(DW - 1)) r_st <= ST_UDSTO;
                end
                ST_UDSTO: begin
                    r_un[r_c] <= r_neg[r_c] ? -r_dn[31:0] : r_dn[31:0];
                    if (r_c != 2'd2) begin
                        r_c  <= r_c + 2'd1;
                        r_st <= ST_UDINIT;
                    end else begin
                        r_c  <= 2'd0;
                        r_st <= ST_USTO;
                    end
                end
                ST_USTO: begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_uvn) begin
                            r_on[tvnt_pkg::idx9(r_k, 2'(i))] <= r_un[i];
                        end else begin
                            for (int j = 0; j < 3; j++) begin
                                r_on[tvnt_pkg::idx9(2'(j), 2'(i))] <= r_un[i];
                            end
                        end
                    end
                    r_r <= 2'd0;
                    r_c <= 2'd0;
                    if (r_uvn && r_k != 2'd2) begin
                        r_k   <= r_k + 2'd1;
                        r_acc <= '0;
                        r_st  <= ST_NMAC;
                    end else begin
                        r_k  <= 2'd0;
                        r_st <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (i_m_tready) begin
                        if (r_k == 2'd2) begin
                            r_k  <= 2'd0;
                            r_st <= ST_IDLE;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    // result of corner r_k
    assign w_oi0 = tvnt_pkg::idx9(r_k, 2'd0);
    assign w_oi1 = tvnt_pkg::idx9(r_k, 2'd1);
    assign w_oi2 = tvnt_pkg::idx9(r_k, 2'd2);

    assign o_m_tvalid = (r_st == ST_OUT);
    assign o_m_tdata  = {r_on[w_oi2], r_on[w_oi1], r_on[w_oi0],
                         r_op[w_oi2], r_op[w_oi1], r_op[w_oi0]};
    assign o_m_tuser  = {r_sat, r_approx, r_k};
    assign o_m_tlast  = (r_k == 2'd2);

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while results are pending");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("corner count out of range");

    a_third_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && r_cnt == 2'd2) |=> !o_s_tready)
        else $error("third corner did not start the sequencer");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("unit not idle after last result");

    a_face_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !r_uvn) |-> !r_approx)
        else $error("approx flag set with face normals");
`endif

endmodule
